FILE: sv/oklch2rgb_pkg.sv
// Shared constants, lookup tables and helpers for the OKLCH to sRGB converter.
package oklch2rgb_pkg;

	localparam int FRAC  = 20;            // fraction bits of the internal fixed point
	localparam int GBITS = 8;             // log2 of the gamma table segment count
	localparam int GSIZE = 1 << GBITS;
	localparam int NSTG  = 8;             // pipeline register stages
	localparam int CQ    = 28;            // fraction bits of the matrix coefficients

	localparam int LW = FRAC + 1;         // unsigned lightness / clamped linear value
	localparam int AW = FRAC + 1;         // signed a, b
	localparam int MW = FRAC + 4;         // signed LMS value
	localparam int SW = FRAC + 6;         // signed LMS square
	localparam int CW = FRAC + 8;         // signed LMS cube
	localparam int KW = 32;               // signed coefficient

	localparam longint unsigned ONE30 = 64'd1 << 30;

	typedef logic [30:0] q30_t;
	typedef q30_t sine_rom_t [0:256];
	typedef q30_t gamma_rom_t [0:GSIZE];

	typedef struct packed {
		logic neg;
		q30_t mag;
	} trig_t;

	function automatic longint unsigned mul30(input longint unsigned a, input longint unsigned b);
		return (a * b + (ONE30 >> 1)) >> 30;
	endfunction

	function automatic longint unsigned isqrt64(input longint unsigned n_in);
		longint unsigned n;
		longint unsigned res;
		longint unsigned bv;
		n = n_in;
		res = 0;
		bv = 64'd1 << 62;
		while (bv > n) bv = bv >> 2;
		while (bv != 0) begin
			if (n >= res + bv) begin
				n = n - (res + bv);
				res = (res >> 1) + bv;
			end else begin
				res = res >> 1;
			end
			bv = bv >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned cbrt30(input longint unsigned x);
		longint unsigned y;
		longint unsigned t;
		y = 0;
		for (int b = 30; b >= 0; b--) begin
			t = y | (64'd1 << b);
			if (t <= ONE30 && mul30(mul30(t, t), t) <= x) y = t;
		end
		return y;
	endfunction

	// sRGB transfer curve on a Q0.30 value
	function automatic longint unsigned encode30(input longint unsigned x);
		longint unsigned c;
		longint unsigned s;
		longint unsigned y;
		longint unsigned e;
		longint unsigned off;
		if (x * 64'd10000000 <= (64'd31308 << 30)) return (x * 64'd1292 + 64'd50) / 64'd100;
		c = cbrt30(x);
		s = isqrt64(c << 30);
		y = mul30(c, isqrt64(s << 30));
		e = (64'd1055 * y + 64'd500) / 64'd1000;
		off = ((64'd55 << 30) + 64'd500) / 64'd1000;
		return (e > off) ? e - off : 64'd0;
	endfunction

	// quarter-wave sine, Taylor series to eight terms
	function automatic sine_rom_t build_sine();
		sine_rom_t r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		for (int k = 0; k <= 256; k++) begin
			x = (64'(unsigned'(k)) * 64'd1686629713 + 64'd128) >> 8;
			x2 = mul30(x, x);
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 7; n++) begin
				term = mul30(term, x2);
				case (n)
					1: term = term / 64'd6;
					2: term = term / 64'd20;
					3: term = term / 64'd42;
					4: term = term / 64'd72;
					5: term = term / 64'd110;
					6: term = term / 64'd156;
					default: term = term / 64'd210;
				endcase
				if ((n % 2) == 1) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			if (sum < 0) sum = 0;
			if (sum > longint'(ONE30)) sum = longint'(ONE30);
			r[k] = q30_t'(sum);
		end
		return r;
	endfunction

	function automatic gamma_rom_t build_gamma();
		gamma_rom_t r;
		for (int k = 0; k <= GSIZE; k++)
			r[k] = q30_t'(encode30(64'(unsigned'(k)) << (30 - GBITS)));
		return r;
	endfunction

	localparam sine_rom_t  SINE_ROM  = build_sine();
	localparam gamma_rom_t GAMMA_ROM = build_gamma();

	// Q.28 coefficient from a value given in units of 1e-10
	function automatic logic signed [KW-1:0] coef(input longint unsigned d, input logic neg);
		longint unsigned m;
		m = (d * 64'd268435456 + 64'd5000000000) / 64'd10000000000;
		return neg ? -KW'(m) : KW'(m);
	endfunction

	localparam logic signed [KW-1:0] LMS_K [3][2] = '{
		'{coef(64'd3963377774, 1'b0), coef(64'd2158037573, 1'b0)},
		'{coef(64'd1055613458, 1'b1), coef(64'd638541728, 1'b1)},
		'{coef(64'd894841775, 1'b1),  coef(64'd12914855480, 1'b1)}
	};

	localparam logic signed [KW-1:0] RGB_K [3][3] = '{
		'{coef(64'd40767416621, 1'b0), coef(64'd33077115913, 1'b1), coef(64'd2309699292, 1'b0)},
		'{coef(64'd12684380046, 1'b1), coef(64'd26097574011, 1'b0), coef(64'd3413193965, 1'b1)},
		'{coef(64'd41960863, 1'b1),    coef(64'd7034186147, 1'b1),  coef(64'd17076147010, 1'b0)}
	};

	// sine of a turn fraction: quadrant fold, table read, linear interpolation
	function automatic trig_t sin_turn(input logic [15:0] h);
		logic [14:0] p;
		logic [8:0] idx;
		logic [5:0] fr;
		q30_t lo;
		q30_t hi;
		logic [36:0] step;
		trig_t t;
		p = {1'b0, h[13:0]};
		if (h[14]) p = 15'd16384 - p;
		idx = p[14:6];
		fr = p[5:0];
		if (idx[8]) begin
			t.mag = SINE_ROM[256];
		end else begin
			lo = SINE_ROM[idx];
			hi = SINE_ROM[idx + 9'd1];
			step = 37'(hi - lo) * 37'(fr) + 37'd32;
			t.mag = lo + q30_t'(step >> 6);
		end
		t.neg = h[15];
		return t;
	endfunction

endpackage

FILE: sv/oklch2rgb_trig.sv
// Lightness scaling and polar to rectangular conversion (stages 1 and 2).
module oklch2rgb_trig (
	input  logic                                    clk,
	input  logic [oklch2rgb_pkg::NSTG-1:0]          adv,
	input  logic [15:0]                             lightness,
	input  logic [14:0]                             chroma,
	input  logic [15:0]                             hue_turn,
	output logic [oklch2rgb_pkg::LW-1:0]            l_s2,
	output logic signed [oklch2rgb_pkg::AW-1:0]     a_s2,
	output logic signed [oklch2rgb_pkg::AW-1:0]     b_s2
);
	import oklch2rgb_pkg::*;

	localparam int TS = 46 - FRAC;   // shift of chroma * trig product

	logic [LW-1:0] rsum;
	logic [LW-17:0] kq;
	logic [16:0] rem;
	logic [LW-1:0] lval;

	logic [LW-1:0] l_s1;
	logic [14:0] chr_s1;
	trig_t sin_s1;
	trig_t cos_s1;

	logic [45:0] pa;
	logic [45:0] pb;
	logic signed [46:0] sa;
	logic signed [46:0] sb;

	// L = round(lum * 2^F / 65535); 2^F = 2^(F-16) * 65535 + 2^(F-16)
	always_comb begin
		rsum = LW'({lightness, {(FRAC-16){1'b0}}}) + LW'(32767);
		kq = rsum[LW-1:16];
		rem = 17'(rsum[15:0]) + 17'(kq);
		if (rem >= 17'd65535) lval = LW'({lightness, {(FRAC-16){1'b0}}}) + LW'(kq) + LW'(1);
		else lval = LW'({lightness, {(FRAC-16){1'b0}}}) + LW'(kq);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			l_s1 <= lval;
			chr_s1 <= chroma;
			sin_s1 <= sin_turn(hue_turn);
			cos_s1 <= sin_turn(hue_turn + 16'd16384);
		end
	end

	always_comb begin
		pa = 46'(chr_s1) * 46'(cos_s1.mag);
		pb = 46'(chr_s1) * 46'(sin_s1.mag);
		sa = cos_s1.neg ? -signed'({1'b0, pa}) : signed'({1'b0, pa});
		sb = sin_s1.neg ? -signed'({1'b0, pb}) : signed'({1'b0, pb});
		sa = sa + (47'sd1 <<< (TS - 1));
		sb = sb + (47'sd1 <<< (TS - 1));
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			l_s2 <= l_s1;
			a_s2 <= AW'(sa >>> TS);
			b_s2 <= AW'(sb >>> TS);
		end
	end

endmodule

FILE: sv/oklch2rgb_lms.sv
// OKLab to LMS, cubing and LMS to linear sRGB with clamp (stages 3 to 6).
module oklch2rgb_lms (
	input  logic                                        clk,
	input  logic [oklch2rgb_pkg::NSTG-1:0]              adv,
	input  logic [oklch2rgb_pkg::LW-1:0]                l_s2,
	input  logic signed [oklch2rgb_pkg::AW-1:0]         a_s2,
	input  logic signed [oklch2rgb_pkg::AW-1:0]         b_s2,
	output logic [2:0][oklch2rgb_pkg::LW-1:0]           x_s6
);
	import oklch2rgb_pkg::*;

	localparam logic signed [AW+KW:0] HALF_K  = (AW+KW+1)'(1) <<< (CQ - 1);
	localparam logic signed [2*MW-1:0] HALF_SQ = (2*MW)'(1) <<< (FRAC - 1);
	localparam logic signed [SW+MW-1:0] HALF_CU = (SW+MW)'(1) <<< (FRAC - 1);
	localparam logic signed [KW+CW+1:0] HALF_R  = (KW+CW+2)'(1) <<< (CQ - 1);
	localparam logic signed [KW+CW+1:0] ONE_F   = (KW+CW+2)'(1) <<< FRAC;

	logic signed [AW+KW:0] ml [3];
	logic signed [2*MW-1:0] p2 [3];
	logic signed [SW+MW-1:0] p3 [3];
	logic signed [KW+CW+1:0] lin [3];

	logic signed [MW-1:0] lms_s3 [3];
	logic signed [MW-1:0] lms_s4 [3];
	logic signed [SW-1:0] sq_s4 [3];
	logic signed [CW-1:0] cub_s5 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ml[i] = a_s2 * LMS_K[i][0] + b_s2 * LMS_K[i][1] + HALF_K;
			p2[i] = lms_s3[i] * lms_s3[i] + HALF_SQ;
			p3[i] = sq_s4[i] * lms_s4[i] + HALF_CU;
			lin[i] = RGB_K[i][0] * cub_s5[0] + RGB_K[i][1] * cub_s5[1]
				+ RGB_K[i][2] * cub_s5[2] + HALF_R;
			lin[i] = lin[i] >>> CQ;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (adv[2]) lms_s3[i] <= signed'(MW'(l_s2)) + MW'(ml[i] >>> CQ);
			if (adv[3]) begin
				sq_s4[i] <= SW'(p2[i] >>> FRAC);
				lms_s4[i] <= lms_s3[i];
			end
			if (adv[4]) cub_s5[i] <= CW'(p3[i] >>> FRAC);
			if (adv[5]) begin
				// out of gamut saturates to 0 or 1
				if (lin[i] < 0) x_s6[i] <= '0;
				else if (lin[i] > ONE_F) x_s6[i] <= LW'(ONE_F);
				else x_s6[i] <= LW'(lin[i]);
			end
		end
	end

endmodule

FILE: sv/oklch2rgb_gamma.sv
// sRGB transfer curve and byte rounding (stages 7 and 8).
module oklch2rgb_gamma (
	input  logic                                clk,
	input  logic [oklch2rgb_pkg::NSTG-1:0]      adv,
	input  logic [2:0][oklch2rgb_pkg::LW-1:0]   x_s6,
	output logic [2:0][7:0]                     byte_s8
);
	import oklch2rgb_pkg::*;

	localparam int SH = FRAC - GBITS;
	localparam longint unsigned LIN_T = (64'd31308 << FRAC) / 64'd10000000;
	localparam longint unsigned LIN_M = 64'd1292 << (30 - FRAC);
	localparam longint unsigned LIN_Q = LIN_M / 64'd100;
	localparam longint unsigned LIN_R = LIN_M % 64'd100;

	logic [15:0] m [3];
	logic [15:0] d [3];
	logic [GBITS:0] gidx [3];
	logic [SH-1:0] gfr [3];
	q30_t lo [3];
	q30_t hi [3];
	logic [30+SH:0] step [3];
	q30_t enc [3];
	q30_t enc_s7 [3];
	logic [39:0] bw [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// linear segment: x * LIN_M / 100 split into quotient and small remainder
			m[i] = 16'(64'(x_s6[i]) * LIN_R + 64'd50);
			d[i] = 16'((32'(m[i]) * 32'd5243) >> 19);
			gidx[i] = x_s6[i][LW-1:SH];
			gfr[i] = x_s6[i][SH-1:0];
			lo[i] = GAMMA_ROM[gidx[i]];
			hi[i] = gidx[i][GBITS] ? GAMMA_ROM[GSIZE] : GAMMA_ROM[gidx[i] + (GBITS+1)'(1)];
			step[i] = (31+SH)'(hi[i] - lo[i]) * (31+SH)'(gfr[i]) + ((31+SH)'(1) << (SH - 1));
			if (64'(x_s6[i]) <= LIN_T) enc[i] = q30_t'(64'(x_s6[i]) * LIN_Q) + q30_t'(d[i]);
			else if (gidx[i][GBITS]) enc[i] = GAMMA_ROM[GSIZE];
			else enc[i] = lo[i] + q30_t'(step[i] >> SH);
			bw[i] = ((40'(enc_s7[i]) << 8) - 40'(enc_s7[i]) + (40'd1 << 29)) >> 30;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (adv[6]) enc_s7[i] <= enc[i];
			if (adv[7]) byte_s8[i] <= (bw[i] > 40'd255) ? 8'd255 : bw[i][7:0];
		end
	end

endmodule

FILE: sv/oklch_to_srgb_converter_top.sv
// Top level of the OKLCH to 8-bit sRGB converter pipeline.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  input   | in        | in_valid / in_stall | lightness, chroma, hue_turn, opacity_in
//  output  | out       | out_valid/out_stall | red, green, blue, opacity_out
//
// An accepted word passes through the eight register stages to the output registers;
// one word enters per cycle while in_stall is low.
// Reset clears only the stage valid bits; payload registers hold no reset.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up and in_stall rises only when all eight stages hold a word.
module oklch_to_srgb_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] lightness,
	input  logic [14:0] chroma,
	input  logic [15:0] hue_turn,
	input  logic [15:0] opacity_in,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [15:0] opacity_out,
	output logic        out_valid,
	input  logic        out_stall
);
	import oklch2rgb_pkg::*;

	logic [NSTG-1:0] vld_s;     // valid bit per stage
	logic [NSTG-1:0] adv;       // stage load enable
	logic [15:0] opa_s [NSTG];  // alpha rides alongside the color math

	logic [LW-1:0] l_s2;
	logic signed [AW-1:0] a_s2;
	logic signed [AW-1:0] b_s2;
	logic [2:0][LW-1:0] x_s6;
	logic [2:0][7:0] byte_s8;

	// load chain, back from the output register
	always_comb begin
		adv[NSTG-1] = !vld_s[NSTG-1] || !out_stall;
		for (int i = NSTG - 2; i >= 0; i--) adv[i] = !vld_s[i] || adv[i+1];
	end

	assign in_stall = !adv[0];
	assign out_valid = vld_s[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) vld_s[0] <= in_valid;
			for (int i = 1; i < NSTG; i++)
				if (adv[i]) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) opa_s[0] <= opacity_in;
		for (int i = 1; i < NSTG; i++)
			if (adv[i]) opa_s[i] <= opa_s[i-1];
	end

	// stages 1-2: L scaling, hue to a/b
	oklch2rgb_trig u_trig (
		.clk       (clk),
		.adv       (adv),
		.lightness (lightness),
		.chroma    (chroma),
		.hue_turn  (hue_turn),
		.l_s2      (l_s2),
		.a_s2      (a_s2),
		.b_s2      (b_s2)
	);

	// stages 3-6: matrices and cube
	oklch2rgb_lms u_lms (
		.clk  (clk),
		.adv  (adv),
		.l_s2 (l_s2),
		.a_s2 (a_s2),
		.b_s2 (b_s2),
		.x_s6 (x_s6)
	);

	// stages 7-8: transfer curve, byte
	oklch2rgb_gamma u_gamma (
		.clk     (clk),
		.adv     (adv),
		.x_s6    (x_s6),
		.byte_s8 (byte_s8)
	);

	assign red = byte_s8[0];
	assign green = byte_s8[1];
	assign blue = byte_s8[2];
	assign opacity_out = opa_s[NSTG-1];

	// input is held off only with every stage full
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_s))
		else $error("in_stall with an empty stage");

	// at most one word enters per cycle; none duplicated
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_s) <= $past($countones(vld_s)) + 1)
		else $error("word count grew by more than one");

	// an output draining frees the input in the same cycle
	a_drain_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |-> adv[0])
		else $error("input stalled while output drains");

endmodule
